// ===== design/prw_pkg.sv =====
`default_nettype none

package prw_pkg;

  localparam int unsigned SOURCE_COUNT = 4;
  localparam int unsigned WINDOW_BITS  = 32;

  localparam int unsigned SRC_W  = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int unsigned SHIFT_W = $clog2(WINDOW_BITS);

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned CNT_W = 32;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 160;
  localparam int unsigned OUT_TUSER_W = 4;

  typedef logic [WINDOW_BITS-1:0] mask_t;

  typedef enum logic [2:0] {
    OUT_FIRST   = 3'd0,
    OUT_NEWER   = 3'd1,
    OUT_LATE    = 3'd2,
    OUT_REPEAT  = 3'd3,
    OUT_TOO_OLD = 3'd4,
    OUT_BAD_SRC = 3'd5
  } outcome_e;

  typedef struct packed {
    logic              accepted;
    outcome_e          outcome;
    logic [SEQ_W-1:0]  new_top;
    mask_t             new_mask;
    logic [CNT_W-1:0]  gap_add;
    logic              repeat_inc;
    logic              late_inc;
  } upd_t;

endpackage

`default_nettype wire

// ===== design/prw_window_update.sv =====
`default_nettype none

module prw_window_update (
  input  wire logic                       started_i,
  input  wire logic [prw_pkg::SEQ_W-1:0]  top_i,
  input  wire prw_pkg::mask_t             mask_i,
  input  wire logic [prw_pkg::SEQ_W-1:0]  seq_i,
  output prw_pkg::upd_t                   upd_o
);

  logic [prw_pkg::SEQ_W-1:0]   step;
  logic [prw_pkg::SEQ_W-1:0]   back;
  logic [prw_pkg::SHIFT_W-1:0] step_sh;
  logic [prw_pkg::SHIFT_W-1:0] back_sh;
  prw_pkg::mask_t              back_bit;
  prw_pkg::mask_t              shifted;

  assign step     = seq_i - top_i;
  assign back     = top_i - seq_i;
  assign step_sh  = step[prw_pkg::SHIFT_W-1:0];
  assign back_sh  = back[prw_pkg::SHIFT_W-1:0];
  assign back_bit = prw_pkg::mask_t'(1) << back_sh;
  assign shifted  = (mask_i << step_sh) | prw_pkg::mask_t'(1);

  always_comb begin
    upd_o.accepted   = 1'b0;
    upd_o.outcome    = prw_pkg::OUT_REPEAT;
    upd_o.new_top    = top_i;
    upd_o.new_mask   = mask_i;
    upd_o.gap_add    = '0;
    upd_o.repeat_inc = 1'b0;
    upd_o.late_inc   = 1'b0;
    if (!started_i) begin
      upd_o.accepted = 1'b1;
      upd_o.outcome  = prw_pkg::OUT_FIRST;
      upd_o.new_top  = seq_i;
      upd_o.new_mask = prw_pkg::mask_t'(1);
    end else if (seq_i > top_i) begin
      upd_o.accepted = 1'b1;
      upd_o.outcome  = prw_pkg::OUT_NEWER;
      upd_o.new_top  = seq_i;
      upd_o.gap_add  = step - prw_pkg::CNT_W'(1);
      // a jump past the window leaves only the new top marked
      if (step >= prw_pkg::SEQ_W'(prw_pkg::WINDOW_BITS)) begin
        upd_o.new_mask = prw_pkg::mask_t'(1);
      end else begin
        upd_o.new_mask = shifted;
      end
    end else if (back >= prw_pkg::SEQ_W'(prw_pkg::WINDOW_BITS)) begin
      upd_o.outcome    = prw_pkg::OUT_TOO_OLD;
      upd_o.repeat_inc = 1'b1;
    end else if ((mask_i & back_bit) != '0) begin
      upd_o.outcome    = prw_pkg::OUT_REPEAT;
      upd_o.repeat_inc = 1'b1;
    end else begin
      upd_o.accepted = 1'b1;
      upd_o.outcome  = prw_pkg::OUT_LATE;
      upd_o.new_mask = mask_i | back_bit;
      upd_o.late_inc = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/per_source_replay_window.sv =====
// per-source anti-replay window
// input stream: one beat per packet header, tdata = source id and sequence number.
// output stream: one beat per input beat, in order; tuser carries the accept flag
// and the outcome code, tdata the window of that source after the update and the
// running gap, repeat and late totals.
// path: the input beat is taken into the input register, then the per-source
// read-modify-write writes the result beat into the result register.
// throughput: one beat per cycle while tready is high, set by the read-modify-write
// of the per-source table; packets of the same source may follow back to back.
// reset: all windows closed, all totals zero, both streams empty.
// stall: while the receiver holds tready low the result beat holds, one more
// input beat is taken into the input register, then tready goes low upstream.
// sequence numbers compare as plain unsigned values; totals wrap at 2^32.
// an out-of-range source gives outcome bad source with zero window fields.
`default_nettype none

module per_source_replay_window (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // source_id [7:0], seq_number [39:8]
  input  wire logic [prw_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // window_top [31:0], window_bits [63:32], gap_total [95:64],
  // repeat_total [127:96], late_total [159:128]
  output logic [prw_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // accepted [0], outcome [3:1]
  output logic [prw_pkg::OUT_TUSER_W-1:0]        m_axis_tuser_o
);

  logic                       in_valid_q;
  logic [7:0]                 src_q;
  logic [prw_pkg::SEQ_W-1:0]  seq_q;

  logic [prw_pkg::SOURCE_COUNT-1:0] started_q;
  logic [prw_pkg::SEQ_W-1:0]        top_q  [prw_pkg::SOURCE_COUNT];
  prw_pkg::mask_t                   mask_q [prw_pkg::SOURCE_COUNT];

  logic [prw_pkg::CNT_W-1:0] gap_q, gap_d;
  logic [prw_pkg::CNT_W-1:0] rep_q, rep_d;
  logic [prw_pkg::CNT_W-1:0] late_q, late_d;

  logic                                out_valid_q;
  logic [prw_pkg::OUT_TDATA_W-1:0]     tdata_q, tdata_d;
  logic [prw_pkg::OUT_TUSER_W-1:0]     tuser_q, tuser_d;

  logic                      out_free;
  logic                      advance;
  logic                      in_take;
  logic                      bad_src;
  logic [prw_pkg::SRC_W-1:0] idx;
  prw_pkg::upd_t             upd;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  assign bad_src = src_q >= 8'(prw_pkg::SOURCE_COUNT);
  assign idx     = src_q[prw_pkg::SRC_W-1:0];

  prw_window_update u_update (
    .started_i (started_q[idx]),
    .top_i     (top_q[idx]),
    .mask_i    (mask_q[idx]),
    .seq_i     (seq_q),
    .upd_o     (upd)
  );

  always_comb begin
    gap_d   = gap_q;
    rep_d   = rep_q;
    late_d  = late_q;
    tuser_d = {prw_pkg::OUT_BAD_SRC, 1'b0};
    if (!bad_src) begin
      gap_d   = gap_q + upd.gap_add;
      rep_d   = rep_q + prw_pkg::CNT_W'(upd.repeat_inc);
      late_d  = late_q + prw_pkg::CNT_W'(upd.late_inc);
      tuser_d = {upd.outcome, upd.accepted};
    end
    tdata_d = {late_d, rep_d, gap_d,
               bad_src ? 32'd0 : 32'(upd.new_mask),
               bad_src ? 32'd0 : upd.new_top};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      started_q   <= '0;
      gap_q       <= '0;
      rep_q       <= '0;
      late_q      <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        gap_q  <= gap_d;
        rep_q  <= rep_d;
        late_q <= late_d;
        if (!bad_src) begin
          started_q[idx] <= 1'b1;
        end
      end
    end
  end

  // payload and per-source window storage, qualified by the valid bits above
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      src_q <= s_axis_tdata_i[7:0];
      seq_q <= s_axis_tdata_i[39:8];
    end
    if (advance) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
      if (!bad_src) begin
        top_q[idx]  <= upd.new_top;
        mask_q[idx] <= upd.new_mask;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

endmodule

`default_nettype wire

// ===== design/prw_checker.sv =====
`default_nettype none

module prw_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [prw_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [prw_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  logic [2:0] outcome;
  logic       acc;

  assign outcome = m_axis_tuser_o[3:1];
  assign acc     = m_axis_tuser_o[0];

  // a stalled result beat stays presented
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_accept_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (acc == (outcome == prw_pkg::OUT_FIRST ||
                                 outcome == prw_pkg::OUT_NEWER ||
                                 outcome == prw_pkg::OUT_LATE)))
    else $error("accept flag disagrees with outcome");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (outcome <= prw_pkg::OUT_BAD_SRC))
    else $error("outcome code out of range");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && outcome == prw_pkg::OUT_BAD_SRC) |-> (m_axis_tdata_o[63:0] == 64'd0))
    else $error("bad source result carries window data");

  // the top of an open window is always marked as seen
  a_top_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && outcome != prw_pkg::OUT_BAD_SRC) |-> m_axis_tdata_o[32])
    else $error("window top not marked in mask");

endmodule

bind per_source_replay_window prw_checker u_prw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== test/per_source_replay_window_checker.sv =====
`timescale 1ns / 100ps

module per_source_replay_window_checker
  import prw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_TDATA_W-1:0] out_data_i,
  input  logic [OUT_TUSER_W-1:0] out_user_i,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic        accepted;
    outcome_e    outcome;
    logic [31:0] top;
    logic [31:0] bits;
    logic [31:0] gaps;
    logic [31:0] repeats;
    logic [31:0] lates;
  } window_verdict_t;

  logic              opened   [SOURCE_COUNT];
  logic [SEQ_W-1:0]  highest  [SOURCE_COUNT];
  mask_t             received [SOURCE_COUNT];
  logic [CNT_W-1:0]  gap_sum;
  logic [CNT_W-1:0]  repeat_sum;
  logic [CNT_W-1:0]  late_sum;

  window_verdict_t   verdict_q [$];
  int                mismatch_count;

  initial begin
    errors_o  = 0;
    pending_o = 0;
    mismatch_count = 0;
  end

  function automatic window_verdict_t window_update(input logic [7:0] src,
                                                    input logic [31:0] seq);
    window_verdict_t v;
    logic [31:0]     step;
    logic [31:0]     back;
    mask_t           bit_sel;
    v = '0;
    if (src >= SOURCE_COUNT) begin
      v.outcome = OUT_BAD_SRC;
    end else if (!opened[src]) begin
      opened[src]   = 1'b1;
      highest[src]  = seq;
      received[src] = mask_t'(1);
      v.accepted    = 1'b1;
      v.outcome     = OUT_FIRST;
    end else if (seq > highest[src]) begin
      step = seq - highest[src];
      gap_sum = gap_sum + step - 32'd1;
      if (step >= WINDOW_BITS)
        received[src] = mask_t'(1);
      else
        received[src] = (received[src] << step) | mask_t'(1);
      highest[src] = seq;
      v.accepted   = 1'b1;
      v.outcome    = OUT_NEWER;
    end else begin
      back = highest[src] - seq;
      if (back >= WINDOW_BITS) begin
        repeat_sum = repeat_sum + 32'd1;
        v.outcome  = OUT_TOO_OLD;
      end else begin
        bit_sel = mask_t'(1) << back;
        if ((received[src] & bit_sel) != '0) begin
          repeat_sum = repeat_sum + 32'd1;
          v.outcome  = OUT_REPEAT;
        end else begin
          received[src] = received[src] | bit_sel;
          late_sum   = late_sum + 32'd1;
          v.accepted = 1'b1;
          v.outcome  = OUT_LATE;
        end
      end
    end
    if (src < SOURCE_COUNT) begin
      v.top  = highest[src];
      v.bits = 32'(received[src]);
    end
    v.gaps    = gap_sum;
    v.repeats = repeat_sum;
    v.lates   = late_sum;
    return v;
  endfunction

  task automatic check_result_beat();
    window_verdict_t want;
    window_verdict_t got;
    got.accepted = out_user_i[0];
    got.outcome  = outcome_e'(out_user_i[3:1]);
    got.top      = out_data_i[31:0];
    got.bits     = out_data_i[63:32];
    got.gaps     = out_data_i[95:64];
    got.repeats  = out_data_i[127:96];
    got.lates    = out_data_i[159:128];
    if (verdict_q.size() == 0) begin
      if (mismatch_count < 10)
        $display("%0t: result beat with nothing pending: acc=%0b out=%0d top=%h bits=%h",
                 $realtime, got.accepted, got.outcome, got.top, got.bits);
      mismatch_count++;
    end else begin
      want = verdict_q.pop_front();
      if (got !== want) begin
        if (mismatch_count < 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected acc=%0b out=%0d top=%h bits=%h gap=%h rep=%h late=%h",
                   want.accepted, want.outcome, want.top, want.bits,
                   want.gaps, want.repeats, want.lates);
          $display("  actual   acc=%0b out=%0d top=%h bits=%h gap=%h rep=%h late=%h",
                   got.accepted, got.outcome, got.top, got.bits,
                   got.gaps, got.repeats, got.lates);
        end
        mismatch_count++;
      end
    end
  endtask

  // result beat is checked before the new input beat is queued; a result never leaves in the same cycle as its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SOURCE_COUNT; i++) begin
        opened[i]   = 1'b0;
        highest[i]  = '0;
        received[i] = '0;
      end
      gap_sum    = '0;
      repeat_sum = '0;
      late_sum   = '0;
      verdict_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i)
        check_result_beat();
      if (in_valid_i && in_ready_i)
        verdict_q.push_back(window_update(in_data_i[7:0], in_data_i[39:8]));
      pending_o <= verdict_q.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

// ===== test/tb_per_source_replay_window.sv =====
`timescale 1ns / 100ps

module tb_per_source_replay_window;
  import prw_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;

  int          mismatches;
  int          outstanding;
  int unsigned sender_idle_pct = 20;
  int unsigned receiver_idle_pct = 63;
  logic [31:0] stim_top [SOURCE_COUNT];

  per_source_replay_window DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  per_source_replay_window_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_i  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_i (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_i  (m_axis_tdata_o),
    .out_user_i  (m_axis_tuser_o),
    .errors_o    (mismatches),
    .pending_o   (outstanding)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i)
    m_axis_tready_i <= ($urandom_range(99) >= receiver_idle_pct);

  task automatic send_packet(input logic [7:0] src, input logic [31:0] seq);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {seq, src};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (src < SOURCE_COUNT && seq > stim_top[src])
      stim_top[src] = seq;
  endtask

  // mostly in-window traffic around each source's top, with some noise
  task automatic random_packets(input int count);
    logic [7:0]  src;
    logic [31:0] seq;
    logic [31:0] base;
    logic [31:0] back;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8)
        src = 8'($urandom_range(255, SOURCE_COUNT));
      else
        src = 8'($urandom_range(SOURCE_COUNT - 1));
      base = stim_top[src % SOURCE_COUNT];
      pick = $urandom_range(99);
      if (pick < 40) begin
        seq = base + 32'($urandom_range(34, 1));
      end else if (pick < 75) begin
        back = 32'($urandom_range(36));
        seq  = (back > base) ? 32'($urandom) : base - back;
      end else if (pick < 85) begin
        seq = base + 32'($urandom_range(1 << 16, 1));
      end else if (pick < 92) begin
        seq = base;
      end else begin
        seq = 32'($urandom);
      end
      send_packet(src, seq);
    end
  endtask

  initial begin
    for (int i = 0; i < SOURCE_COUNT; i++) stim_top[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // bad sources before anything opens
    send_packet(8'd4, 32'd7);
    send_packet(8'hff, 32'hffff_ffff);
    // source 0: open, same number as top, step, late, repeat, window edge
    send_packet(8'd0, 32'd100);
    send_packet(8'd0, 32'd100);
    send_packet(8'd0, 32'd101);
    send_packet(8'd0, 32'd99);
    send_packet(8'd0, 32'd99);
    send_packet(8'd0, 32'd69);
    send_packet(8'd0, 32'd70);
    send_packet(8'd0, 32'd133);
    send_packet(8'd0, 32'd164);
    send_packet(8'd0, 32'd133);
    // source 1 opens at the very top
    send_packet(8'd1, 32'hffff_ffff);
    send_packet(8'd1, 32'd0);
    send_packet(8'd1, 32'hffff_fffe);
    send_packet(8'd1, 32'hffff_ffe0);
    // large jumps push the gap total past a wrap
    send_packet(8'd2, 32'd0);
    send_packet(8'd2, 32'hffff_ffff);
    send_packet(8'd3, 32'd0);
    send_packet(8'd3, 32'hffff_ffff);
    send_packet(8'd3, 32'hffff_ffe1);
    send_packet(8'd2, 32'hffff_fffd);
    send_packet(8'd5, 32'h1234_5678);

    random_packets(220);
    sender_idle_pct   = 63;
    receiver_idle_pct = 20;
    random_packets(240);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    random_packets(240);

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
design/prw_pkg.sv
design/prw_window_update.sv
design/per_source_replay_window.sv
design/prw_checker.sv
test/per_source_replay_window_checker.sv
test/tb_per_source_replay_window.sv
